@@ hdl/kbp_pkg.sv @@
// Shared types and constants for the keyed buffer pool with aging.
`default_nettype none

package kbp_pkg;

    localparam int KEY_W          = 38;
    localparam int HANDLE_W       = 4;
    localparam int HANDLE_SPACE   = 16;
    localparam int AGE_W          = 4;
    localparam int LIMIT_W        = 3;
    localparam int POOL_DEPTH_DEF = 16;
    localparam int S_TDATA_W      = 48;
    localparam int M_TDATA_W      = 24;
    localparam int TARGET_LSB     = KEY_W;

    // Age is stored offset by one: code 0 means age -1 (in use), code 15 means 14.
    localparam logic [AGE_W-1:0]   AGE_BUSY    = 4'd0;
    localparam logic [AGE_W-1:0]   AGE_TOP     = 4'd15;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 3'd2;

    typedef enum logic [1:0] {
        OP_BORROW    = 2'd0,
        OP_RETURN    = 2'd1,
        OP_DEFER     = 2'd2,
        OP_END_FRAME = 2'd3
    } op_e;

    typedef enum logic [1:0] {
        USE_FREE  = 2'd0,
        USE_BUSY  = 2'd1,
        USE_DEFER = 2'd2
    } use_e;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NO_HANDLE = 2'd2
    } status_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_COMPACT,
        ST_DONE
    } state_e;

    typedef struct packed {
        logic                valid;
        logic [KEY_W-1:0]    key;
        use_e                usage;
        logic [AGE_W-1:0]    age;
        logic [HANDLE_W-1:0] handle;
    } slot_t;

    typedef struct packed {
        logic                exec;
        logic                shift;
        op_e                 op;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] target;
        logic [AGE_W-1:0]    limit_p1;
    } cell_cmd_t;

    typedef struct packed {
        logic                    any_hit;
        logic [HANDLE_W-1:0]     hit_handle;
        logic                    full;
        logic [HANDLE_W-1:0]     new_handle;
        logic                    tgt_found;
        logic [HANDLE_SPACE-1:0] rm_mask;
        logic                    unsorted;
    } pool_sum_t;

endpackage

`default_nettype wire

@@ hdl/kbp_cell.sv @@
// One pool entry: key match, handle lookup, aging and left shift for compaction.
`default_nettype none

module kbp_cell (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire kbp_pkg::cell_cmd_t          cmd,
    input  wire logic                        alloc_en,
    input  wire logic [kbp_pkg::HANDLE_W-1:0] new_handle,
    input  wire logic                        prev_valid,
    input  wire logic                        hit_in,
    input  wire logic                        hole_in,
    input  wire kbp_pkg::slot_t              right,
    output kbp_pkg::slot_t                   slot,
    output logic                             hit_out,
    output logic                             take,
    output logic                             tgt_hit,
    output logic                             expire,
    output logic                             hole_out,
    output logic                             unsorted
);

    kbp_pkg::slot_t           slot_reg;
    kbp_pkg::slot_t           slot_next;
    logic                     hit_match;
    logic [kbp_pkg::AGE_W-1:0] age_inc;

    assign slot = slot_reg;

    always_comb begin
        hit_match = slot_reg.valid && (slot_reg.usage == kbp_pkg::USE_FREE) &&
                    (slot_reg.key == cmd.key);
        take      = cmd.exec && (cmd.op == kbp_pkg::OP_BORROW) && hit_match && !hit_in;
        hit_out   = hit_in || hit_match;
        tgt_hit   = slot_reg.valid && (slot_reg.handle == cmd.target);
        if ((slot_reg.usage == kbp_pkg::USE_FREE) && (slot_reg.age != kbp_pkg::AGE_TOP)) begin
            age_inc = slot_reg.age + 4'd1;
        end else begin
            age_inc = slot_reg.age;
        end
        expire    = slot_reg.valid && (age_inc > cmd.limit_p1);
        hole_out  = hole_in || !slot_reg.valid;
        unsorted  = slot_reg.valid && hole_in;

        slot_next = slot_reg;
        if (cmd.shift && (hole_in || !slot_reg.valid)) begin
            // pull the right neighbor in over a hole
            slot_next = right;
        end else if (cmd.exec) begin
            case (cmd.op)
                kbp_pkg::OP_BORROW: begin
                    if (take) begin
                        slot_next.usage = kbp_pkg::USE_BUSY;
                        slot_next.age   = kbp_pkg::AGE_BUSY;
                    end else if (alloc_en && !slot_reg.valid && prev_valid) begin
                        slot_next.valid  = 1'b1;
                        slot_next.key    = cmd.key;
                        slot_next.usage  = kbp_pkg::USE_BUSY;
                        slot_next.age    = kbp_pkg::AGE_BUSY;
                        slot_next.handle = new_handle;
                    end
                end
                kbp_pkg::OP_RETURN: begin
                    if (tgt_hit) begin
                        slot_next.usage = kbp_pkg::USE_FREE;
                    end
                end
                kbp_pkg::OP_DEFER: begin
                    if (tgt_hit) begin
                        slot_next.usage = kbp_pkg::USE_DEFER;
                    end
                end
                kbp_pkg::OP_END_FRAME: begin
                    if (slot_reg.valid) begin
                        slot_next.age = age_inc;
                        if (slot_reg.usage == kbp_pkg::USE_DEFER) begin
                            slot_next.usage = kbp_pkg::USE_FREE;
                        end
                        // drop expired entries, leaving a hole for compaction
                        slot_next.valid = !expire;
                    end
                end
                default: begin
                    slot_next = slot_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg.valid <= 1'b0;
        end else begin
            slot_reg <= slot_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/kbp_ctrl.sv @@
// Request capture, sequencing state machine, limit register and result register.
`default_nettype none

module kbp_ctrl (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [kbp_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic [1:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [kbp_pkg::M_TDATA_W-1:0]          m_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [kbp_pkg::LIMIT_W-1:0]       cfg_wdata,
    input  wire kbp_pkg::pool_sum_t                sum,
    output kbp_pkg::cell_cmd_t                     cmd
);

    kbp_pkg::state_e                     state_reg, state_next;
    kbp_pkg::op_e                        op_reg;
    logic [kbp_pkg::KEY_W-1:0]           key_reg;
    logic [kbp_pkg::HANDLE_W-1:0]        tgt_reg;
    logic [kbp_pkg::LIMIT_W-1:0]         limit_reg;
    logic [kbp_pkg::HANDLE_W-1:0]        rh_reg, rh_next;
    logic                                created_reg, created_next;
    kbp_pkg::status_e                    status_reg, status_next;
    logic [kbp_pkg::HANDLE_SPACE-1:0]    mask_reg, mask_next;
    logic                                m_valid_reg, m_valid_next;
    logic [kbp_pkg::M_TDATA_W-1:0]       m_data_reg, m_data_next;
    logic                                accept;

    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        rh_next      = rh_reg;
        created_next = created_reg;
        status_next  = status_reg;
        mask_next    = mask_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;

        cmd.exec     = 1'b0;
        cmd.shift    = 1'b0;
        cmd.op       = op_reg;
        cmd.key      = key_reg;
        cmd.target   = tgt_reg;
        cmd.limit_p1 = {1'b0, limit_reg} + 4'd1;

        case (state_reg)
            kbp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = kbp_pkg::ST_EXEC;
                end
            end
            kbp_pkg::ST_EXEC: begin
                cmd.exec     = 1'b1;
                rh_next      = '0;
                created_next = 1'b0;
                status_next  = kbp_pkg::STATUS_OK;
                mask_next    = '0;
                state_next   = kbp_pkg::ST_DONE;
                case (op_reg)
                    kbp_pkg::OP_BORROW: begin
                        if (sum.any_hit) begin
                            rh_next = sum.hit_handle;
                        end else if (sum.full) begin
                            status_next = kbp_pkg::STATUS_FULL;
                        end else begin
                            rh_next      = sum.new_handle;
                            created_next = 1'b1;
                        end
                    end
                    kbp_pkg::OP_RETURN, kbp_pkg::OP_DEFER: begin
                        if (!sum.tgt_found) begin
                            status_next = kbp_pkg::STATUS_NO_HANDLE;
                        end
                    end
                    kbp_pkg::OP_END_FRAME: begin
                        mask_next  = sum.rm_mask;
                        state_next = kbp_pkg::ST_COMPACT;
                    end
                    default: begin
                        state_next = kbp_pkg::ST_DONE;
                    end
                endcase
            end
            kbp_pkg::ST_COMPACT: begin
                // shift one step per cycle until the valid entries form a prefix
                cmd.shift = sum.unsorted;
                if (!sum.unsorted) begin
                    state_next = kbp_pkg::ST_DONE;
                end
            end
            kbp_pkg::ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, mask_reg, status_reg, created_reg, rh_reg};
                    state_next   = kbp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = kbp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= kbp_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            limit_reg   <= kbp_pkg::LIMIT_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= kbp_pkg::op_e'(s_tuser);
            key_reg <= s_tdata[kbp_pkg::KEY_W-1:0];
            tgt_reg <= s_tdata[kbp_pkg::TARGET_LSB +: kbp_pkg::HANDLE_W];
        end
        rh_reg      <= rh_next;
        created_reg <= created_next;
        status_reg  <= status_next;
        mask_reg    <= mask_next;
        m_data_reg  <= m_data_next;
    end

endmodule

`default_nettype wire

@@ hdl/keyed_buffer_pool_with_aging_unit.sv @@
// Top level: controller plus a chain of pool entry cells with their reductions.
// Sequencing: borrow, return and deferred return pass through the execute and done states
// before m_tvalid rises; end of frame also passes through the compaction state, which makes
// at most one shift per removed entry. A new request is taken only in the idle state, after
// the last result has been loaded; a stalled result holds the next one in the done state until it leaves.
// Reset (aresetn low, synchronous): pool empty, idle frame limit 2, no result pending.
`default_nettype none

module keyed_buffer_pool_with_aging_unit #(
    parameter int POOL_DEPTH = kbp_pkg::POOL_DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // req_width[13:0], req_height[27:14], req_color_count[32:28], req_flags[37:33],
    // target_handle[41:38], zero fill [47:42]
    input  wire logic [kbp_pkg::S_TDATA_W-1:0] s_tdata,
    // op[1:0]
    input  wire logic [1:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // result_handle[3:0], created[4], status[6:5], removed_mask[22:7], zero fill [23]
    output logic [kbp_pkg::M_TDATA_W-1:0]      m_tdata,
    input  wire logic                          cfg_we,
    input  wire logic [kbp_pkg::LIMIT_W-1:0]   cfg_wdata
);

    localparam int CAP = (POOL_DEPTH < kbp_pkg::HANDLE_SPACE) ? POOL_DEPTH
                                                             : kbp_pkg::HANDLE_SPACE;

    kbp_pkg::cell_cmd_t               cmd;
    kbp_pkg::pool_sum_t               sum;
    kbp_pkg::slot_t                   slots    [CAP];
    kbp_pkg::slot_t                   rights   [CAP];
    logic [CAP:0]                     hit_chain;
    logic [CAP:0]                     hole_chain;
    logic [CAP-1:0]                   prev_valid;
    logic [CAP-1:0]                   take;
    logic [CAP-1:0]                   tgt_hit;
    logic [CAP-1:0]                   expire;
    logic [CAP-1:0]                   unsorted;
    logic [kbp_pkg::HANDLE_SPACE-1:0] used_mask;
    logic                             alloc_en;

    assign hit_chain[0]  = 1'b0;
    assign hole_chain[0] = 1'b0;
    assign alloc_en      = !sum.any_hit && !sum.full;

    kbp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sum       (sum),
        .cmd       (cmd)
    );

    for (genvar i = 0; i < CAP; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign prev_valid[i] = 1'b1;
        end else begin : g_rest
            assign prev_valid[i] = slots[i-1].valid;
        end
        if (i == CAP - 1) begin : g_last
            assign rights[i] = '0;
        end else begin : g_inner
            assign rights[i] = slots[i+1];
        end

        kbp_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .alloc_en   (alloc_en),
            .new_handle (sum.new_handle),
            .prev_valid (prev_valid[i]),
            .hit_in     (hit_chain[i]),
            .hole_in    (hole_chain[i]),
            .right      (rights[i]),
            .slot       (slots[i]),
            .hit_out    (hit_chain[i+1]),
            .take       (take[i]),
            .tgt_hit    (tgt_hit[i]),
            .expire     (expire[i]),
            .hole_out   (hole_chain[i+1]),
            .unsorted   (unsorted[i])
        );
    end

    always_comb begin
        used_mask      = '0;
        sum.hit_handle = '0;
        sum.rm_mask    = '0;
        for (int i = 0; i < CAP; i++) begin
            if (slots[i].valid) begin
                used_mask = used_mask | (16'd1 << slots[i].handle);
            end
            if (take[i]) begin
                sum.hit_handle = sum.hit_handle | slots[i].handle;
            end
            if (expire[i]) begin
                sum.rm_mask = sum.rm_mask | (16'd1 << slots[i].handle);
            end
        end
        // lowest handle not in use
        sum.new_handle = '0;
        for (int h = kbp_pkg::HANDLE_SPACE - 1; h >= 0; h--) begin
            if (!used_mask[h]) begin
                sum.new_handle = kbp_pkg::HANDLE_W'(h);
            end
        end
        sum.any_hit   = hit_chain[CAP];
        sum.full      = slots[CAP-1].valid;
        sum.tgt_found = |tgt_hit;
        sum.unsorted  = |unsorted;
    end

endmodule

`default_nettype wire

@@ hdl/kbp_checker.sv @@
// Port-level checks for the keyed buffer pool, bound to the top level.
`default_nettype none

module kbp_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [kbp_pkg::M_TDATA_W-1:0] m_tdata
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request at a time: input closes right after a transaction
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transaction");

    a_created_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> m_tdata[6:5] == 2'd0 && m_tdata[22:7] == 16'd0)
        else $error("created result carries status or removed mask");

    a_mask_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[22:7] != 16'd0 |->
            m_tdata[3:0] == 4'd0 && !m_tdata[4] && m_tdata[6:5] == 2'd0)
        else $error("removed mask together with borrow fields");

endmodule

bind keyed_buffer_pool_with_aging_unit kbp_checker u_kbp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ bench/keyed_buffer_pool_with_aging_unit_tb.sv @@
// Self-checking testbench for the keyed buffer pool: borrow, return, defer, frame aging.
`timescale 1ns / 100ps

module keyed_buffer_pool_with_aging_unit_tb;
    import kbp_pkg::*;

    localparam int POOL_CAP     = (POOL_DEPTH_DEF < HANDLE_SPACE) ? POOL_DEPTH_DEF
                                                                  : HANDLE_SPACE;
    localparam int AGE_CEILING  = 14;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 300000;

    // Packs exactly into s_tdata[37:0]: width lowest, flags highest.
    typedef struct packed {
        logic [4:0]  flags;
        logic [4:0]  colors;
        logic [13:0] height;
        logic [13:0] width;
    } buf_key_t;

    // Packs exactly into m_tdata[22:0].
    typedef struct packed {
        logic [15:0] removed;
        logic [1:0]  status;
        logic        created;
        logic [3:0]  handle;
    } pool_reply_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]           s_tuser = OP_BORROW;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we = 1'b0;
    logic [LIMIT_W-1:0]   cfg_wdata = '0;

    // Pool as the block should hold it, in list order.
    buf_key_t    ent_key[POOL_CAP];
    use_e        ent_use[POOL_CAP];
    int          ent_age[POOL_CAP];
    logic [3:0]  ent_handle[POOL_CAP];
    int          pool_count = 0;
    int          idle_limit = LIMIT_RESET;

    pool_reply_t pending_replies[$];
    buf_key_t    key_palette[5];

    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int stall_left = 0;
    int cycle_count = 0;
    int errors = 0;
    int n_requests = 0;
    int n_checked = 0;
    int n_created = 0;
    int n_full = 0;
    int n_unknown = 0;
    int n_frames = 0;
    int n_removed = 0;

    keyed_buffer_pool_with_aging_unit #(
        .POOL_DEPTH(POOL_DEPTH_DEF)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d replies outstanding",
                     cycle_count, pending_replies.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int random_pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic buf_key_t random_key();
        buf_key_t k;
        k.width  = 14'($urandom_range(0, 16383));
        k.height = 14'($urandom_range(0, 16383));
        k.colors = 5'($urandom_range(0, 16));
        k.flags  = 5'($urandom_range(0, 31));
        return k;
    endfunction

    // Apply one request to the pool and return the reply it must produce.
    function automatic pool_reply_t model_request(op_e op, buf_key_t key, logic [3:0] target);
        pool_reply_t rep;
        int          pos;
        int          w;
        int          h;
        logic [15:0] used;
        rep = '0;
        rep.status = STATUS_OK;
        case (op)
            OP_BORROW: begin
                pos = -1;
                for (int i = 0; i < pool_count; i++)
                    if (pos < 0 && ent_use[i] == USE_FREE && ent_key[i] == key) pos = i;
                if (pos >= 0) begin
                    ent_use[pos] = USE_BUSY;
                    ent_age[pos] = -1;
                    rep.handle = ent_handle[pos];
                end else if (pool_count >= POOL_CAP) begin
                    rep.status = STATUS_FULL;
                    n_full++;
                end else begin
                    used = '0;
                    for (int i = 0; i < pool_count; i++) used[ent_handle[i]] = 1'b1;
                    h = 0;
                    while (used[h]) h++;
                    ent_key[pool_count]    = key;
                    ent_use[pool_count]    = USE_BUSY;
                    ent_age[pool_count]    = -1;
                    ent_handle[pool_count] = 4'(h);
                    pool_count++;
                    rep.handle  = 4'(h);
                    rep.created = 1'b1;
                    n_created++;
                end
            end
            OP_RETURN, OP_DEFER: begin
                pos = -1;
                for (int i = 0; i < pool_count; i++)
                    if (ent_handle[i] == target) pos = i;
                if (pos < 0) begin
                    rep.status = STATUS_NO_HANDLE;
                    n_unknown++;
                end else begin
                    ent_use[pos] = (op == OP_RETURN) ? USE_FREE : USE_DEFER;
                end
            end
            default: begin
                n_frames++;
                for (int i = 0; i < pool_count; i++) begin
                    if (ent_use[i] == USE_FREE) begin
                        if (ent_age[i] < AGE_CEILING) ent_age[i]++;
                    end else if (ent_use[i] == USE_DEFER) begin
                        ent_use[i] = USE_FREE;
                    end
                end
                // Drop expired entries and close the gaps, keeping list order.
                w = 0;
                for (int i = 0; i < pool_count; i++) begin
                    if (ent_age[i] > idle_limit) begin
                        rep.removed[ent_handle[i]] = 1'b1;
                        n_removed++;
                    end else begin
                        ent_key[w]    = ent_key[i];
                        ent_use[w]    = ent_use[i];
                        ent_age[w]    = ent_age[i];
                        ent_handle[w] = ent_handle[i];
                        w++;
                    end
                end
                pool_count = w;
            end
        endcase
        return rep;
    endfunction

    // Hold valid across back-to-back transactions; lower it only for a gap.
    task automatic send_request(input op_e op, input buf_key_t key, input logic [3:0] target);
        int gap;
        gap = tx_steady ? 0 : random_pause_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, target, key};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        pending_replies.push_back(model_request(op, key, target));
        n_requests++;
    endtask

    task automatic finish_outstanding();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_idle_limit(input int lim);
        finish_outstanding();
        cfg_we    <= 1'b1;
        cfg_wdata <= LIMIT_W'(lim);
        @(posedge aclk);
        cfg_we <= 1'b0;
        idle_limit = lim;
    endtask

    // Runs at the reset limit: reuse order, busy and deferred entries, repeated returns,
    // unknown handles, and removal with compaction.
    task automatic test_borrow_return_basics();
        buf_key_t k_min;
        buf_key_t k_max;
        buf_key_t k_min_f1;
        buf_key_t k_alt;
        k_min    = '0;
        k_max    = '{flags: 5'd31, colors: 5'd16, height: 14'h3FFF, width: 14'h3FFF};
        k_min_f1 = '{flags: 5'd1, colors: 5'd0, height: 14'h0, width: 14'h0};
        k_alt    = '{flags: 5'b10101, colors: 5'd15, height: 14'h1555, width: 14'h2AAA};
        send_request(OP_BORROW, k_min, 4'd15);
        send_request(OP_BORROW, k_max, 4'd0);
        send_request(OP_BORROW, k_min, 4'd7);
        send_request(OP_RETURN, random_key(), 4'd0);
        send_request(OP_BORROW, k_min, 4'd3);
        send_request(OP_BORROW, k_min_f1, 4'd8);
        send_request(OP_RETURN, k_max, 4'd15);
        send_request(OP_DEFER, random_key(), 4'd1);
        send_request(OP_BORROW, k_max, 4'd1);
        send_request(OP_DEFER, random_key(), 4'd1);
        send_request(OP_RETURN, random_key(), 4'd2);
        send_request(OP_RETURN, random_key(), 4'd2);
        send_request(OP_DEFER, random_key(), 4'd0);
        send_request(OP_RETURN, random_key(), 4'd0);
        send_request(OP_BORROW, k_alt, 4'd15);
        repeat (4) send_request(OP_END_FRAME, random_key(), 4'($urandom_range(0, 15)));
        send_request(OP_RETURN, random_key(), 4'd2);
    endtask

    task automatic test_pool_exhaustion();
        logic [3:0] held[$];
        buf_key_t   k;
        buf_key_t   spare;
        int         i;
        set_idle_limit(0);
        // Release everything so two frame ends empty the pool.
        for (i = 0; i < pool_count; i++) held.push_back(ent_handle[i]);
        foreach (held[j]) send_request(OP_RETURN, random_key(), held[j]);
        repeat (2) send_request(OP_END_FRAME, random_key(), 4'($urandom_range(0, 15)));
        i = 0;
        while (pool_count < POOL_CAP) begin
            k.width  = 14'(i);
            k.height = 14'(16383 - i);
            k.colors = 5'(i);
            k.flags  = 5'(31 - i);
            send_request(OP_BORROW, k, 4'($urandom_range(0, 15)));
            i++;
        end
        spare = '{flags: 5'd0, colors: 5'd16, height: 14'd7, width: 14'd9};
        send_request(OP_BORROW, spare, 4'd0);
        send_request(OP_RETURN, random_key(), ent_handle[5]);
        send_request(OP_BORROW, ent_key[5], 4'd0);
        send_request(OP_BORROW, spare, 4'd0);
        send_request(OP_DEFER, random_key(), ent_handle[0]);
        send_request(OP_END_FRAME, random_key(), 4'd0);
    endtask

    task automatic test_random_traffic();
        int       phase_limit[8];
        int       r;
        op_e      op;
        buf_key_t key;
        logic [3:0] target;
        phase_limit = '{0, 6, 3, 1, 5, 4, 2, 6};
        for (int ph = 0; ph < 8; ph++) begin
            set_idle_limit(phase_limit[ph]);
            tx_steady = (ph % 4 == 1) || (ph % 4 == 2);
            rx_steady = (ph % 4 == 1) || (ph % 4 == 3);
            for (int k = 0; k < 5; k++) key_palette[k] = random_key();
            // Near miss: differs from another palette key in one flag bit only.
            key_palette[4] = key_palette[0];
            key_palette[4].flags[$urandom_range(0, 4)] ^= 1'b1;
            for (int n = 0; n < 48; n++) begin
                r      = $urandom_range(0, 99);
                key    = random_key();
                target = 4'($urandom_range(0, 15));
                if (r < 40) begin
                    op = OP_BORROW;
                    if ($urandom_range(0, 99) < 85) key = key_palette[$urandom_range(0, 4)];
                end else if (r < 80) begin
                    op = (r < 65) ? OP_RETURN : OP_DEFER;
                    if (pool_count > 0 && $urandom_range(0, 9) != 0)
                        target = ent_handle[$urandom_range(0, pool_count - 1)];
                end else begin
                    op = OP_END_FRAME;
                end
                send_request(op, key, target);
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            stall_left = rx_steady ? 0 : random_pause_len();
            m_tready <= (stall_left == 0);
        end
    end

    always @(posedge aclk) begin : reply_check
        pool_reply_t got;
        pool_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[22:0];
            if (pending_replies.size() == 0) begin
                $error("reply with nothing outstanding: m_tdata=%h", m_tdata);
                errors++;
            end else begin
                want = pending_replies.pop_front();
                n_checked++;
                if (got.handle !== want.handle) begin
                    $error("result_handle: expected %0d, actual %0d", want.handle, got.handle);
                    errors++;
                end
                if (got.created !== want.created) begin
                    $error("created: expected %0d, actual %0d", want.created, got.created);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    errors++;
                end
                if (got.removed !== want.removed) begin
                    $error("removed_mask: expected %h, actual %h", want.removed, got.removed);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_borrow_return_basics();
        test_pool_exhaustion();
        test_random_traffic();
        finish_outstanding();
        $display("Sent %0d requests, checked %0d replies: %0d created, %0d pool full,",
                 n_requests, n_checked, n_created, n_full);
        $display("%0d unknown handles, %0d frame ends removing %0d entries, %0d errors",
                 n_unknown, n_frames, n_removed, errors);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
